### src/wot_pkg.sv
// wheel odometry tracker package: widths and fixed-point constants, arctangent table
// for the cordic, and the saturate and rounding helpers used by the top-level datapath
// no dependencies
package wot_pkg;

  localparam int HDG_W  = 17;
  localparam int CNT_W  = 32;
  localparam int POS_W  = 48;
  localparam int OFF_W  = 11;
  localparam int CIRC_W = 12;

  localparam int MUL_AW = 50;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int RQ_W   = MUL_PW - 30;
  localparam int DIV_NW = 60;
  localparam int DIV_DW = 42;
  localparam int CX_W   = 34;
  localparam int CZ_W   = 33;
  localparam int TRIG_W = 32;

  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;

  localparam logic signed [MUL_BW-1:0] PI_Q28   = 32'sd843314857;
  localparam logic signed [MUL_AW-1:0] PI_Q30   = 50'sd3373259426;
  localparam logic signed [MUL_BW-1:0] GAIN_Q30 = 32'sd652032874;

  localparam logic signed [63:0] POS_MAX64 = 64'sh00007FFFFFFFFFFF;
  localparam logic signed [63:0] POS_MIN64 = 64'shFFFF800000000000;

  typedef enum logic [1:0] {
    REG_BACK_OFF = 2'd0,
    REG_MID_OFF  = 2'd1,
    REG_CIRC     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [POS_W-1:0] sat48(input logic signed [63:0] v);
    if (v > POS_MAX64) begin
      return POS_MAX64[POS_W-1:0];
    end else if (v < POS_MIN64) begin
      return POS_MIN64[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

  // round to nearest, ties upward, drop 30 fraction bits
  function automatic logic signed [RQ_W-1:0] round_q30(input logic signed [MUL_PW-1:0] p);
    logic signed [MUL_PW-1:0] s;
    s = p + (MUL_PW'(1) <<< 29);
    return s[MUL_PW-1:30];
  endfunction

  function automatic logic [30:0] atan_q30(input logic [4:0] k);
    case (k)
      5'd0:  return 31'h3243F6A8;
      5'd1:  return 31'h1DAC6705;
      5'd2:  return 31'h0FADBAFC;
      5'd3:  return 31'h07F56EA6;
      5'd4:  return 31'h03FEAB76;
      5'd5:  return 31'h01FFD55B;
      5'd6:  return 31'h00FFFAAA;
      5'd7:  return 31'h007FFF55;
      5'd8:  return 31'h003FFFEA;
      5'd9:  return 31'h001FFFFD;
      5'd10: return 31'h000FFFFF;
      5'd11: return 31'h0007FFFF;
      5'd12: return 31'h0003FFFF;
      5'd13: return 31'h0001FFFF;
      5'd14: return 31'h0000FFFF;
      5'd15: return 31'h00007FFF;
      5'd16: return 31'h00003FFF;
      5'd17: return 31'h00001FFF;
      5'd18: return 31'h00000FFF;
      5'd19: return 31'h000007FF;
      5'd20: return 31'h000003FF;
      5'd21: return 31'h000001FF;
      5'd22: return 31'h000000FF;
      5'd23: return 31'h0000007F;
      5'd24: return 31'h0000003F;
      5'd25: return 31'h0000001F;
      5'd26: return 31'h0000000F;
      5'd27: return 31'h00000008;
      5'd28: return 31'h00000004;
      5'd29: return 31'h00000002;
      5'd30: return 31'h00000001;
      default: return 31'h00000000;
    endcase
  endfunction

endpackage

### src/wot_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on wot_pkg
module wot_mul import wot_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output unit_stat_t               stat,
  output logic signed [MUL_PW-1:0] prod
);

  localparam int CW = $clog2(MUL_BW);

  logic signed [MUL_AW-1:0] a_r;
  logic signed [MUL_AW-1:0] hi_r;
  logic [MUL_BW-1:0]        lo_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic                     last;
  logic signed [MUL_AW:0]   addend;
  logic signed [MUL_AW:0]   sum;

  always_comb begin
    last = (cnt_r == CW'(MUL_BW - 1));
    if (!lo_r[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -(MUL_AW+1)'(a_r);
    end else begin
      addend = (MUL_AW+1)'(a_r);
    end
    sum = (MUL_AW+1)'(hi_r) + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && busy_r && last;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        hi_r   <= '0;
        lo_r   <= b;
        a_r    <= a;
      end else if (busy_r) begin
        hi_r  <= sum[MUL_AW:1];
        lo_r  <= {sum[0], lo_r[MUL_BW-1:1]};
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = {hi_r, lo_r};

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier done without a preceding busy cycle");

endmodule

### src/wot_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on wot_pkg
module wot_div import wot_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output unit_stat_t        stat,
  output logic [DIV_NW-1:0] quo
);

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, quo_r[DIV_NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = !diff[DIV_DW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && busy_r && (cnt_r == CW'(DIV_NW - 1));
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        quo_r <= {quo_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

### src/wot_cordic.sv
// rotation-mode cordic, one iteration per cycle, unscaled sine and cosine
// depends on wot_pkg (arctangent table)
module wot_cordic import wot_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic signed [CZ_W-1:0] z0,
  output unit_stat_t             stat,
  output logic signed [CX_W-1:0] x,
  output logic signed [CX_W-1:0] y
);

  localparam int KW = $clog2(STEPS);

  logic signed [CX_W-1:0] x_r;
  logic signed [CX_W-1:0] y_r;
  logic signed [CZ_W-1:0] z_r;
  logic [KW-1:0]          k_r;
  logic                   busy_r;
  logic                   done_r;
  logic signed [CX_W-1:0] x_sh;
  logic signed [CX_W-1:0] y_sh;
  logic signed [CZ_W-1:0] ang;

  always_comb begin
    x_sh = x_r >>> k_r;
    y_sh = y_r >>> k_r;
    ang  = $signed({2'b00, atan_q30(5'(k_r))});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && busy_r && (k_r == KW'(STEPS - 1));
      if (go) begin
        busy_r <= 1'b1;
        k_r    <= '0;
        x_r    <= CX_W'(1) <<< 30;
        y_r    <= '0;
        z_r    <= z0;
      end else if (busy_r) begin
        if (!z_r[CZ_W-1]) begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - ang;
        end else begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + ang;
        end
        k_r <= k_r + KW'(1);
        if (k_r == KW'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign x         = x_r;
  assign y         = y_r;

endmodule

### src/wheel_odometry_tracker_unit.sv
// Tracking-wheel odometry: each input transfer is one sample (heading, left, right and
// lateral wheel counts) and yields one output transfer with the saturating global x/y
// position, FRAC_BITS fraction bits. The time between input transfers is set by the
// bit-serial multiplier (eight products), the bit-serial divider (two quotients), the
// cordic and any out_tready stall on an older result; samples are processed one at a
// time, and a new sample is taken while the previous result still waits on out_tready.
// Configuration writes are taken at any time and must only be issued while idle.
// top level; depends on wot_pkg, wot_mul, wot_div, wot_cordic
module wheel_odometry_tracker_unit import wot_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // heading_centideg, left_count, right_count, lateral_count, zero pad
  input  logic [119:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // pos_x, pos_y
  output logic [95:0]   out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [11:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL_OD, S_DIV_OD, S_SIDE, S_MUL_Z, S_DIV_Z,
    S_CORDIC, S_GAIN_X, S_GAIN_Y, S_PROJ, S_SUM, S_OUT
  } state_t;

  typedef enum logic [1:0] {P_DY_CS, P_DX_SN, P_DX_CS, P_DY_SN} proj_t;

  state_t state_r;
  proj_t  proj_r;

  logic signed [OFF_W-1:0]  back_off_r;
  logic [CIRC_W-1:0]        circ_r;

  logic signed [HDG_W-1:0]  h_r;
  logic signed [CNT_W-1:0]  left_r;
  logic signed [CNT_W-1:0]  right_r;
  logic signed [CNT_W-1:0]  lat_r;
  logic signed [HDG_W-1:0]  prev_h_r;
  logic signed [POS_W-1:0]  prev_fwd_r;
  logic signed [POS_W-1:0]  prev_lat_r;
  logic signed [POS_W-1:0]  tcl_r;
  logic signed [POS_W-1:0]  gx_r;
  logic signed [POS_W-1:0]  gy_r;

  logic signed [POS_W-1:0]  fwd_r;
  logic signed [POS_W:0]    dx_r;
  logic signed [POS_W:0]    dy_r;
  logic signed [15:0]       r_r;
  logic                     neg_r;
  logic                     sgn_r;
  logic signed [TRIG_W-1:0] cs_r;
  logic signed [TRIG_W-1:0] sn_r;
  logic signed [RQ_W:0]     gdx_r;
  logic signed [RQ_W:0]     gdy_r;

  logic                     out_valid_r;
  logic [95:0]              out_data_r;
  logic                     out_load;

  logic                     mul_go_r;
  logic                     mul_start;
  logic signed [MUL_AW-1:0] mul_a_r;
  logic signed [MUL_BW-1:0] mul_b_r;
  unit_stat_t               mul_stat;
  logic signed [MUL_PW-1:0] mul_prod;

  logic                     div_go_r;
  logic                     div_start;
  logic [DIV_NW-1:0]        div_num_r;
  logic [DIV_DW-1:0]        div_den_r;
  unit_stat_t               div_stat;
  logic [DIV_NW-1:0]        div_quo;

  logic                     cor_go_r;
  logic                     cor_start;
  logic signed [CZ_W-1:0]   cor_z_r;
  unit_stat_t               cor_stat;
  logic signed [CX_W-1:0]   cor_x;
  logic signed [CX_W-1:0]   cor_y;

  logic signed [17:0]       d;
  logic signed [28:0]       od;
  logic signed [32:0]       sum33;
  logic signed [POS_W-1:0]  fwd;
  logic signed [POS_W-1:0]  latf;
  logic signed [POS_W-1:0]  side;
  logic signed [18:0]       hx;
  logic signed [18:0]       rr;
  logic                     rneg;
  logic [CIRC_W-1:0]        circ_eff;
  logic [17:0]              c50;
  logic [DIV_DW-1:0]        den;
  logic signed [DIV_NW-1:0] prod_lo;
  logic [DIV_NW-1:0]        mag;
  logic signed [DIV_NW:0]   qs;
  logic signed [DIV_NW:0]   term;
  logic signed [RQ_W-1:0]   rq;
  logic signed [TRIG_W-1:0] csf;
  logic signed [TRIG_W-1:0] snf;

  always_comb begin
    d     = 18'(h_r) - 18'(prev_h_r);
    od    = 29'(back_off_r) * 29'(d);
    sum33 = 33'(left_r) + 33'(right_r);
    fwd   = 48'(sum33) <<< (FRAC_BITS - 1);
    latf  = 48'(lat_r) <<< FRAC_BITS;
    side  = sat48(64'(latf) - 64'(tcl_r));

    // heading into [0, full turn), then folded to within a quarter turn
    hx = 19'(h_r) + 19'(2 * FULL_TURN);
    if (hx >= 19'(3 * FULL_TURN)) begin
      rr = hx - 19'(3 * FULL_TURN);
    end else if (hx >= 19'(2 * FULL_TURN)) begin
      rr = hx - 19'(2 * FULL_TURN);
    end else if (hx >= 19'(FULL_TURN)) begin
      rr = hx - 19'(FULL_TURN);
    end else begin
      rr = hx;
    end
    if (rr >= 19'(HALF_TURN)) begin
      rr = rr - 19'(FULL_TURN);
    end
    rneg = 1'b0;
    if (rr > 19'(QUARTER_TURN)) begin
      rr   = rr - 19'(HALF_TURN);
      rneg = 1'b1;
    end else if (rr < -19'(QUARTER_TURN)) begin
      rr   = rr + 19'(HALF_TURN);
      rneg = 1'b1;
    end

    circ_eff = (circ_r == '0) ? CIRC_W'(1) : circ_r;
    c50      = (18'(circ_eff) << 5) + (18'(circ_eff) << 4) + (18'(circ_eff) << 1);
    den      = DIV_DW'(c50) << (28 - FRAC_BITS);

    prod_lo = mul_prod[DIV_NW-1:0];
    mag     = prod_lo[DIV_NW-1] ? DIV_NW'(-prod_lo) : DIV_NW'(prod_lo);
    qs      = $signed({1'b0, div_quo});
    term    = sgn_r ? -qs : qs;

    rq  = round_q30(mul_prod);
    csf = neg_r ? -cs_r : cs_r;
    snf = neg_r ? -rq[TRIG_W-1:0] : rq[TRIG_W-1:0];

    out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);
    mul_start = (state_r == S_PREP) || (state_r == S_SIDE) ||
                ((state_r == S_CORDIC) && cor_stat.done) ||
                (((state_r == S_GAIN_X) || (state_r == S_GAIN_Y)) && mul_stat.done) ||
                ((state_r == S_PROJ) && mul_stat.done && (proj_r != P_DY_SN));
    div_start = ((state_r == S_MUL_OD) || (state_r == S_MUL_Z)) && mul_stat.done;
    cor_start = (state_r == S_DIV_Z) && div_stat.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      proj_r      <= P_DY_CS;
      back_off_r  <= OFF_W'(50);
      circ_r      <= CIRC_W'(200);
      prev_h_r    <= '0;
      prev_fwd_r  <= '0;
      prev_lat_r  <= '0;
      tcl_r       <= '0;
      gx_r        <= '0;
      gy_r        <= '0;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      cor_go_r    <= 1'b0;
    end else begin
      mul_go_r <= mul_start;
      div_go_r <= div_start;
      cor_go_r <= cor_start;

      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_BACK_OFF: back_off_r <= cfg_data[OFF_W-1:0];
          // forward compensation cancels in the wheel mean
          REG_MID_OFF:  ;
          REG_CIRC:     circ_r <= cfg_data;
          default:      ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            h_r     <= in_tdata[16:0];
            left_r  <= in_tdata[48:17];
            right_r <= in_tdata[80:49];
            lat_r   <= in_tdata[112:81];
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          fwd_r    <= fwd;
          r_r      <= 16'(rr);
          neg_r    <= rneg;
          mul_a_r  <= MUL_AW'(od);
          mul_b_r  <= PI_Q28;
          state_r  <= S_MUL_OD;
        end
        S_MUL_OD: begin
          if (mul_stat.done) begin
            sgn_r     <= prod_lo[DIV_NW-1];
            div_num_r <= mag + DIV_NW'(den >> 1);
            div_den_r <= den;
            state_r   <= S_DIV_OD;
          end
        end
        S_DIV_OD: begin
          if (div_stat.done) begin
            tcl_r   <= sat48(64'(tcl_r) + 64'(term));
            state_r <= S_SIDE;
          end
        end
        S_SIDE: begin
          dx_r       <= 49'(side) - 49'(prev_lat_r);
          dy_r       <= 49'(fwd_r) - 49'(prev_fwd_r);
          prev_lat_r <= side;
          prev_fwd_r <= fwd_r;
          prev_h_r   <= h_r;
          mul_a_r    <= PI_Q30;
          mul_b_r    <= MUL_BW'(r_r);
          state_r    <= S_MUL_Z;
        end
        S_MUL_Z: begin
          if (mul_stat.done) begin
            sgn_r     <= prod_lo[DIV_NW-1];
            div_num_r <= mag + DIV_NW'(QUARTER_TURN);
            div_den_r <= DIV_DW'(HALF_TURN);
            state_r   <= S_DIV_Z;
          end
        end
        S_DIV_Z: begin
          if (div_stat.done) begin
            cor_z_r  <= term[CZ_W-1:0];
            state_r  <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cor_stat.done) begin
            mul_a_r  <= MUL_AW'(cor_x);
            mul_b_r  <= GAIN_Q30;
            state_r  <= S_GAIN_X;
          end
        end
        S_GAIN_X: begin
          if (mul_stat.done) begin
            cs_r     <= rq[TRIG_W-1:0];
            mul_a_r  <= MUL_AW'(cor_y);
            mul_b_r  <= GAIN_Q30;
            state_r  <= S_GAIN_Y;
          end
        end
        S_GAIN_Y: begin
          if (mul_stat.done) begin
            cs_r     <= csf;
            sn_r     <= snf;
            mul_a_r  <= MUL_AW'(dy_r);
            mul_b_r  <= csf;
            proj_r   <= P_DY_CS;
            state_r  <= S_PROJ;
          end
        end
        S_PROJ: begin
          if (mul_stat.done) begin
            case (proj_r)
              P_DY_CS: begin
                gdy_r    <= (RQ_W+1)'(rq);
                mul_a_r  <= MUL_AW'(dx_r);
                mul_b_r  <= sn_r;
                proj_r   <= P_DX_SN;
              end
              P_DX_SN: begin
                gdy_r    <= gdy_r + (RQ_W+1)'(rq);
                mul_a_r  <= MUL_AW'(dx_r);
                mul_b_r  <= cs_r;
                proj_r   <= P_DX_CS;
              end
              P_DX_CS: begin
                gdx_r    <= (RQ_W+1)'(rq);
                mul_a_r  <= MUL_AW'(dy_r);
                mul_b_r  <= sn_r;
                proj_r   <= P_DY_SN;
              end
              P_DY_SN: begin
                gdx_r   <= gdx_r - (RQ_W+1)'(rq);
                state_r <= S_SUM;
              end
              default: state_r <= S_SUM;
            endcase
          end
        end
        S_SUM: begin
          gx_r    <= sat48(64'(gx_r) + 64'(gdx_r));
          gy_r    <= sat48(64'(gy_r) + 64'(gdy_r));
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r  <= {gy_r, gx_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  wot_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  wot_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  wot_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cor_go_r),
    .z0    (cor_z_r),
    .stat  (cor_stat),
    .x     (cor_x),
    .y     (cor_y)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  a_accept_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !mul_stat.busy && !div_stat.busy && !cor_stat.busy)
    else $error("sample transfer while an arithmetic unit is still busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && (!out_valid_r || out_tready) |=>
      out_valid_r && (state_r == S_IDLE))
    else $error("finished result not loaded into the output register");

  a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_MUL_OD) || (state_r == S_MUL_Z) ||
      (state_r == S_GAIN_X) || (state_r == S_GAIN_Y) || (state_r == S_PROJ))
    else $error("multiplier finished while the sequencer was not waiting for it");

endmodule

### verif/tb_wheel_odometry_tracker_unit.sv
// testbench for wheel_odometry_tracker_unit: random and directed odometry samples,
// a scoreboard class predicting the saturating global position, randomized handshakes
// depends on wot_pkg and the wheel_odometry_tracker_unit rtl
`timescale 1ns / 100ps

module tb_wheel_odometry_tracker_unit;
  import wot_pkg::*;

  localparam int STEPS = 16;
  localparam int FRAC  = 8;
  localparam int LAT_CYC = 450;
  localparam int EXP_DEPTH = 16;
  localparam longint P_MAX = 64'sh00007FFFFFFFFFFF;
  localparam longint P_MIN = -P_MAX - 1;
  localparam longint PIQ28 = 64'sd843314857;
  localparam longint PIQ30 = 64'sd3373259426;
  localparam longint GAINQ30 = 64'sd652032874;

  typedef struct {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
  } position_t;

  class odometry_scoreboard;
    longint arctan_tab[32];
    logic [10:0] back_off, mid_off;
    logic [11:0] circ;
    longint last_hdg, last_fwd, last_side, comp_lat, comp_fwd, gx, gy;
    position_t exp_ring[EXP_DEPTH];
    int wr_ptr, rd_ptr, pending_cnt;
    int mismatches;

    function void init();
      arctan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                     64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                     64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                     64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                     64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                     64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
                     64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
                     64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000};
      back_off = 11'd50; mid_off = 11'd50; circ = 12'd200;
      last_hdg = 0; last_fwd = 0; last_side = 0;
      comp_lat = 0; comp_fwd = 0; gx = 0; gy = 0;
      wr_ptr = 0; rd_ptr = 0; pending_cnt = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_cnt;
    endfunction

    function void write_reg(reg_idx_t idx, logic [11:0] val);
      case (idx)
        REG_BACK_OFF: back_off = val[10:0];
        REG_MID_OFF:  mid_off = val[10:0];
        REG_CIRC:     circ = val;
        default: ;
      endcase
    endfunction

    function longint clamp48(longint v);
      return v > P_MAX ? P_MAX : (v < P_MIN ? P_MIN : v);
    endfunction

    function longint round_div(longint num, longint den);
      longint mag, q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -q : q;
    endfunction

    function longint scale_q30(longint a, longint c);
      longint ah, al, p, q, ph, pl;
      ah = a >>> 24;
      al = a - ah * (64'sd1 << 24);
      p = ah * c;
      q = al * c + (64'sd1 << 29);
      ph = p >>> 6;
      pl = p - ph * 64;
      return ph + ((pl * (64'sd1 << 24) + q) >>> 30);
    endfunction

    function void sin_cos(longint h, output longint cs, output longint sn);
      longint r, x, y, z, t;
      bit flip;
      r = h % 36000; x = 64'sd1 << 30; y = 0; flip = 0;
      if (r < 0) r += 36000;
      if (r >= 18000) r -= 36000;
      if (r > 9000) begin
        r -= 18000; flip = 1;
      end else if (r < -9000) begin
        r += 18000; flip = 1;
      end
      z = round_div(r * PIQ30, 18000);
      for (int i = 0; i < STEPS; i++) begin
        int k;
        k = i & 31;
        if (z >= 0) begin
          t = x - (y >>> k); y = y + (x >>> k); x = t; z -= arctan_tab[k];
        end else begin
          t = x + (y >>> k); y = y - (x >>> k); x = t; z += arctan_tab[k];
        end
      end
      x = (x * GAINQ30 + (64'sd1 << 29)) >>> 30;
      y = (y * GAINQ30 + (64'sd1 << 29)) >>> 30;
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    function longint turn_comp(logic [10:0] off, longint d);
      longint c, den, o;
      c = longint'(circ);
      if (c == 0) c = 1;
      den = 50 * c * (64'sd1 << (28 - FRAC));
      o = longint'($signed(off));
      return round_div(o * d * PIQ28, den);
    endfunction

    function void note_sample(logic [119:0] d);
      longint h, l, r, lat, dh, fwd, side, dy, dx, cs, sn;
      position_t p;
      h = longint'($signed(d[16:0]));
      l = longint'($signed(d[48:17]));
      r = longint'($signed(d[80:49]));
      lat = longint'($signed(d[112:81]));
      dh = h - last_hdg;
      comp_lat = clamp48(comp_lat + turn_comp(back_off, dh));
      comp_fwd = clamp48(comp_fwd + turn_comp(mid_off, dh));
      fwd = (l + r) * (64'sd1 << (FRAC - 1));
      side = clamp48(lat * (64'sd1 << FRAC) - comp_lat);
      dy = fwd - last_fwd;
      dx = side - last_side;
      sin_cos(h, cs, sn);
      gx = clamp48(gx + scale_q30(dx, cs) - scale_q30(dy, sn));
      gy = clamp48(gy + scale_q30(dy, cs) + scale_q30(dx, sn));
      last_fwd = fwd; last_side = side; last_hdg = h;
      p.pos_x = gx[47:0];
      p.pos_y = gy[47:0];
      exp_ring[wr_ptr] = p;
      wr_ptr = (wr_ptr + 1) % EXP_DEPTH;
      pending_cnt++;
    endfunction

    function void check_result(logic [95:0] d);
      position_t p;
      if (pending_cnt == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", d);
        return;
      end
      p = exp_ring[rd_ptr];
      rd_ptr = (rd_ptr + 1) % EXP_DEPTH;
      pending_cnt--;
      if (d[47:0] !== p.pos_x || d[95:48] !== p.pos_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("position mismatch: expected x %h y %h, got x %h y %h",
                   p.pos_x, p.pos_y, d[47:0], d[95:48]);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_valid, cfg_ready;
  logic [119:0] in_tdata;
  logic [95:0] out_tdata;
  logic [1:0] cfg_index;
  logic [11:0] cfg_data;
  bit calm;
  int hold_req, hold_seen, hold_cnt;
  odometry_scoreboard sb;
  longint walk_l, walk_r, walk_lat;
  int walk_h;

  wheel_odometry_tracker_unit #(.CORDIC_STEPS(STEPS), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("FAIL wheel_odometry_tracker_unit");
    $finish;
  end

  // receiver side with random stalls and a long hold-off on request
  initial begin
    out_tready = 0;
    hold_seen = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_sample(logic signed [16:0] h, logic [31:0] l, logic [31:0] r,
                             logic [31:0] lat);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, lat, r, l, h};
    do @(posedge clk); while (!in_tready);
    sb.note_sample({7'd0, lat, r, l, h});
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LAT_CYC) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        walk_h = walk_h + $signed($urandom_range(4000)) - 2000;
        if (walk_h > 36000) walk_h = 36000;
        if (walk_h < -36000) walk_h = -36000;
        walk_l = walk_l + $signed($urandom_range(200000)) - 100000;
        walk_r = walk_r + $signed($urandom_range(200000)) - 100000;
        walk_lat = walk_lat + $signed($urandom_range(200000)) - 100000;
        send_sample(17'(walk_h), 32'(walk_l), 32'(walk_r), 32'(walk_lat));
      end else if ($urandom_range(1)) begin
        send_sample(17'($signed($urandom_range(72000)) - 36000), $urandom, $urandom,
                    $urandom);
      end else begin
        send_sample(17'($urandom), $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic set_config(logic [10:0] bo, logic [10:0] mo, logic [11:0] c);
    write_cfg(REG_BACK_OFF, {1'($urandom), bo});
    write_cfg(REG_MID_OFF, {1'($urandom), mo});
    write_cfg(REG_CIRC, c);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int hdg[13];
    sb = new();
    sb.init();
    in_tvalid = 0; in_tdata = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    calm = 0; hold_req = 0;
    walk_h = 0; walk_l = 0; walk_r = 0; walk_lat = 0;
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    hdg = '{0, 36000, -36000, 9000, 9001, -9001, 18000, -18000, 17999, 27000, 1, -1,
            35999};
    send_sample(17'sd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0300);
    foreach (hdg[i])
      send_sample(17'(hdg[i]), i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                  i[1] ? 32'h7FFF_FFFF : 32'h8000_0000,
                  i[2] ? 32'h7FFF_FFFF : 32'h8000_0000);
    send_sample(17'h10000, 32'hFFFF_FFFF, 32'h0, 32'h1);
    send_sample(17'sd65535, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // zero circumference, extreme offsets
    set_config(11'h3E8, 11'h418, 12'd0);
    send_sample(17'sd36000, 32'd5, 32'd5, 32'd5);
    send_sample(-17'sd36000, 32'd5, 32'd5, 32'd5);
    random_phase(250);
    drain();

    set_config(11'h418, 11'h3E8, 12'd4000);
    calm = 1;
    random_phase(250);
    drain();
    calm = 0;

    set_config(11'h400, 11'h3FF, 12'hFFF);
    hold_req = 1;
    random_phase(250);
    drain();

    set_config(11'd0, 11'd0, 12'd1);
    random_phase(250);
    drain();

    set_config(11'($signed($urandom_range(2000)) - 1000),
               11'($signed($urandom_range(2000)) - 1000),
               12'($urandom_range(4000, 1)));
    random_phase(250);
    drain();

    set_config(11'($urandom), 11'($urandom), 12'($urandom));
    random_phase(250);
    drain();

    if (sb.pending() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("PASS wheel_odometry_tracker_unit");
    end else begin
      $display("FAIL wheel_odometry_tracker_unit");
    end
    $finish;
  end

endmodule

### sim.f
src/wot_pkg.sv
src/wot_mul.sv
src/wot_div.sv
src/wot_cordic.sv
src/wheel_odometry_tracker_unit.sv
verif/tb_wheel_odometry_tracker_unit.sv
